### hw/rtl/arithmetic_expression_lexer_core_macros.svh
// Assertion macros shared by the checkers of the expression lexer.
`ifndef ARITHMETIC_EXPRESSION_LEXER_CORE_MACROS_SVH
`define ARITHMETIC_EXPRESSION_LEXER_CORE_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define AELEX_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lexer assertion failed");

// Next-cycle implication, disabled while rst is high.
`define AELEX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lexer assertion failed");

`endif

### hw/rtl/aelex_pkg.sv
// Types and codes shared by the expression lexer modules.
`default_nettype none
package aelex_pkg;

   localparam int OUT_VALUE_BITS = 32;
   localparam int OUT_POS_BITS   = 16;
   localparam int DIGIT_BITS     = 8;
   localparam int QUEUE_DEPTH    = 4;

   typedef enum logic [2:0] {
      TOK_END_OF_TEXT = 3'd0,
      TOK_NUMBER      = 3'd1,
      TOK_OPERATOR    = 3'd2,
      TOK_OPEN        = 3'd3,
      TOK_CLOSE       = 3'd4,
      TOK_ERROR       = 3'd5
   } token_kind_type;

   typedef enum logic [1:0] {
      OP_PLUS   = 2'd0,
      OP_MINUS  = 2'd1,
      OP_TIMES  = 2'd2,
      OP_DIVIDE = 2'd3
   } op_code_type;

   typedef struct packed {
      token_kind_type            kind;
      op_code_type               op;
      logic [OUT_VALUE_BITS-1:0] value;
      logic [DIGIT_BITS-1:0]     digits;
      logic [OUT_POS_BITS-1:0]   line;
      logic [OUT_POS_BITS-1:0]   column;
      logic                      last;
   } token_word_type;

   // Up to two tokens produced by one input transaction, first in order.
   typedef struct packed {
      logic [1:0]     count;
      token_word_type first;
      token_word_type second;
   } tok_push_type;

endpackage
`default_nettype wire

### hw/rtl/aelex_scan.sv
// Character classification, number accumulation and position tracking.
`default_nettype none
module aelex_scan #(
   parameter int VALUE_BITS    = 32,
   parameter int POSITION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             char_code,
   input  logic                   end_of_text,
   output aelex_pkg::tok_push_type push
);
   import aelex_pkg::*;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_OPEN    = 8'h28;
   localparam logic [7:0] CHAR_CLOSE   = 8'h29;

   localparam logic [POSITION_BITS-1:0] POS_MAX   = {POSITION_BITS{1'b1}};
   localparam logic [DIGIT_BITS-1:0]    DIGIT_MAX = {DIGIT_BITS{1'b1}};
   localparam logic [VALUE_BITS-1:0]    VALUE_MAX = {VALUE_BITS{1'b1}};

   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic [POSITION_BITS-1:0] column_ff, column_in;
   logic                     in_number_ff, in_number_in;
   logic [VALUE_BITS-1:0]    value_ff, value_in;
   logic [DIGIT_BITS-1:0]    digits_ff, digits_in;
   logic [POSITION_BITS-1:0] start_line_ff, start_line_in;
   logic [POSITION_BITS-1:0] start_column_ff, start_column_in;
   logic                     halted_ff, halted_in;

   logic                     is_digit, is_space, is_op, is_open, is_close;
   logic [VALUE_BITS-1:0]    base_value;
   logic [DIGIT_BITS-1:0]    base_digits;
   logic [VALUE_BITS+3:0]    scaled;
   logic                     have_num, have_main;
   token_word_type           num_tok, main_tok;
   op_code_type              op_code;

   assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign is_space = (char_code == CHAR_SPACE)
                     || ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
   assign is_op    = (char_code == CHAR_PLUS) || (char_code == CHAR_MINUS)
                     || (char_code == CHAR_STAR) || (char_code == CHAR_SLASH);
   assign is_open  = (char_code == CHAR_OPEN);
   assign is_close = (char_code == CHAR_CLOSE);

   always_comb begin
      case (char_code)
         CHAR_PLUS:  op_code = OP_PLUS;
         CHAR_MINUS: op_code = OP_MINUS;
         CHAR_STAR:  op_code = OP_TIMES;
         default:    op_code = OP_DIVIDE;
      endcase
   end

   // A fresh number starts from zero; value*10 + digit is formed four bits wider,
   // and any carry into those bits means the maximum was passed.
   assign base_value  = in_number_ff ? value_ff : '0;
   assign base_digits = in_number_ff ? digits_ff : '0;
   assign scaled = ({4'b0, base_value} << 3) + ({4'b0, base_value} << 1)
                   + (VALUE_BITS+4)'(char_code - CHAR_ZERO);

   always_comb begin
      num_tok        = '0;
      num_tok.kind   = TOK_NUMBER;
      num_tok.op     = OP_PLUS;
      num_tok.value  = OUT_VALUE_BITS'(value_ff);
      num_tok.digits = digits_ff;
      num_tok.line   = OUT_POS_BITS'(start_line_ff);
      num_tok.column = OUT_POS_BITS'(start_column_ff);

      main_tok        = '0;
      main_tok.kind   = TOK_END_OF_TEXT;
      main_tok.op     = OP_PLUS;
      main_tok.digits = DIGIT_BITS'(1);
      main_tok.line   = OUT_POS_BITS'(line_ff);
      main_tok.column = OUT_POS_BITS'(column_ff);
      main_tok.last   = 1'b1;

      have_num  = 1'b0;
      have_main = 1'b0;

      line_in         = line_ff;
      column_in       = column_ff;
      in_number_in    = in_number_ff;
      value_in        = value_ff;
      digits_in       = digits_ff;
      start_line_in   = start_line_ff;
      start_column_in = start_column_ff;
      halted_in       = halted_ff;

      if (end_of_text) begin
         have_num        = in_number_ff;
         have_main       = !halted_ff;
         main_tok.digits = '0;
         line_in         = '0;
         column_in       = '0;
         in_number_in    = 1'b0;
         value_in        = '0;
         digits_in       = '0;
         start_line_in   = '0;
         start_column_in = '0;
         halted_in       = 1'b0;
      end else if (!halted_ff) begin
         if (is_digit) begin
            if (!in_number_ff) begin
               start_line_in   = line_ff;
               start_column_in = column_ff;
            end
            in_number_in = 1'b1;
            value_in     = (|scaled[VALUE_BITS+3:VALUE_BITS]) ? VALUE_MAX
                           : scaled[VALUE_BITS-1:0];
            digits_in    = (base_digits == DIGIT_MAX) ? DIGIT_MAX : base_digits + 1'b1;
         end else begin
            have_num     = in_number_ff;
            in_number_in = 1'b0;
            if (is_op) begin
               have_main   = 1'b1;
               main_tok.kind = TOK_OPERATOR;
               main_tok.op   = op_code;
            end else if (is_open) begin
               have_main     = 1'b1;
               main_tok.kind = TOK_OPEN;
            end else if (is_close) begin
               have_main     = 1'b1;
               main_tok.kind = TOK_CLOSE;
            end else if (!is_space) begin
               have_main     = 1'b1;
               main_tok.kind = TOK_ERROR;
               halted_in     = 1'b1;
            end
         end
         // The offending character of an error does not move the position.
         if (!halted_in) begin
            if (char_code == CHAR_NEWLINE) begin
               line_in   = (line_ff == POS_MAX) ? POS_MAX : line_ff + 1'b1;
               column_in = '0;
            end else begin
               column_in = (column_ff == POS_MAX) ? POS_MAX : column_ff + 1'b1;
            end
         end
      end

      num_tok.last = !have_main;
      push.count   = accept ? ({1'b0, have_num} + {1'b0, have_main}) : 2'd0;
      push.first   = have_num ? num_tok : main_tok;
      push.second  = main_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff         <= '0;
         column_ff       <= '0;
         in_number_ff    <= 1'b0;
         value_ff        <= '0;
         digits_ff       <= '0;
         start_line_ff   <= '0;
         start_column_ff <= '0;
         halted_ff       <= 1'b0;
      end else if (accept) begin
         line_ff         <= line_in;
         column_ff       <= column_in;
         in_number_ff    <= in_number_in;
         value_ff        <= value_in;
         digits_ff       <= digits_in;
         start_line_ff   <= start_line_in;
         start_column_ff <= start_column_in;
         halted_ff       <= halted_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/aelex_queue.sv
// Small token queue that takes up to two tokens per cycle and hands out one.
`default_nettype none
module aelex_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  aelex_pkg::tok_push_type   push,
   output logic                      space_ok,
   output logic                      out_valid,
   input  logic                      out_ready,
   output aelex_pkg::token_word_type out_token
);
   import aelex_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   token_word_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] head_ff, head_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [PTR_BITS-1:0] tail, tail_next;
   logic                pop;

   assign tail      = head_ff + count_ff[PTR_BITS-1:0];
   assign tail_next = tail + 1'b1;
   assign out_valid = (count_ff != '0);
   assign out_token = entry_ff[head_ff];
   assign pop       = out_valid && out_ready;
   // Room for the worst case of two tokens from the next transaction.
   assign space_ok  = (count_ff <= CNT_BITS'(QUEUE_DEPTH - 2));

   assign head_in  = pop ? head_ff + 1'b1 : head_ff;
   assign count_in = count_ff - CNT_BITS'(pop) + CNT_BITS'(push.count);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[tail] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[tail_next] <= push.second;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/arithmetic_expression_lexer_core.sv
// Top level of the arithmetic expression lexer.
// Throughput: one character per cycle; a transaction is taken whenever the
// four-entry token queue holds two tokens or fewer, so room for two is left.
// With the queue empty, the first token caused by a character is offered on rsp
// in the cycle after that character is accepted, a second after the first is taken.
// Reset clears position, number and halt state and empties the queue.
`default_nettype none
module arithmetic_expression_lexer_core #(
   parameter int VALUE_BITS    = 32,
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_token_kind,
   output logic [1:0]  rsp_operator_code,
   output logic [31:0] rsp_number_value,
   output logic [7:0]  rsp_digit_count,
   output logic [15:0] rsp_line_index,
   output logic [15:0] rsp_column_index,
   output logic        rsp_last_of_run
);
   import aelex_pkg::*;

   tok_push_type   push;
   token_word_type out_token;
   logic           space_ok;

   assign req_ready = space_ok;

   aelex_scan #(
      .VALUE_BITS    (VALUE_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_valid && space_ok),
      .char_code   (req_char_code),
      .end_of_text (req_end_of_text),
      .push        (push)
   );

   aelex_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_token (out_token)
   );

   assign rsp_token_kind    = out_token.kind;
   assign rsp_operator_code = out_token.op;
   assign rsp_number_value  = out_token.value;
   assign rsp_digit_count   = out_token.digits;
   assign rsp_line_index    = out_token.line;
   assign rsp_column_index  = out_token.column;
   assign rsp_last_of_run   = out_token.last;

endmodule
`default_nettype wire

### hw/rtl/aelex_checker.sv
// Port-level checks of the expression lexer and their binding to the top level.
`default_nettype none
`include "arithmetic_expression_lexer_core_macros.svh"
module aelex_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_char_code,
   input logic        req_end_of_text,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_token_kind,
   input logic [1:0]  rsp_operator_code,
   input logic [31:0] rsp_number_value,
   input logic [7:0]  rsp_digit_count,
   input logic [15:0] rsp_line_index,
   input logic [15:0] rsp_column_index,
   input logic        rsp_last_of_run
);
   import aelex_pkg::*;

   // A stalled result transaction keeps its payload.
   `AELEX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_token_kind, rsp_operator_code, rsp_number_value, rsp_digit_count, rsp_line_index, rsp_column_index, rsp_last_of_run}))

   // Only number tokens carry a value.
   `AELEX_ASSERT_NOW(a_value_number_only, clock, reset, rsp_valid && (rsp_token_kind != TOK_NUMBER), rsp_number_value == '0)

   // End of text always closes its run and has no lexeme.
   `AELEX_ASSERT_NOW(a_eot_shape, clock, reset, rsp_valid && (rsp_token_kind == TOK_END_OF_TEXT), rsp_last_of_run && (rsp_digit_count == '0) && (rsp_operator_code == OP_PLUS))

   // An error is a single-character token that ends its run.
   `AELEX_ASSERT_NOW(a_error_shape, clock, reset, rsp_valid && (rsp_token_kind == TOK_ERROR), rsp_last_of_run && (rsp_digit_count == 8'd1))

   // The queue is empty in the cycle after reset.
   `AELEX_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready)

endmodule

bind arithmetic_expression_lexer_core aelex_checker u_checker (.*);
`default_nettype wire

### test/tb.sv
// Testbench for the expression lexer: directed table, random texts, digit-count saturation.
module tb;
   import aelex_pkg::*;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int HOLD_START  = 400;
   localparam int HOLD_LEN    = 300;
   localparam int RANDOM_ITEMS = 450;

   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_TIMES    = 8'h2A;
   localparam logic [7:0] CH_DIVIDE   = 8'h2F;
   localparam logic [7:0] CH_OPEN     = 8'h28;
   localparam logic [7:0] CH_CLOSE    = 8'h29;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_NEWLINE  = 8'h0A;
   localparam logic [7:0] CH_VTAB     = 8'h0B;
   localparam logic [7:0] CH_FORMFEED = 8'h0C;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_SPACE    = 8'h20;

   localparam logic [15:0] POS_MAX   = 16'hFFFF;
   localparam logic [31:0] VALUE_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      token_kind_type kind;
      op_code_type    op;
      logic [31:0]    value;
      logic [7:0]     digits;
      logic [15:0]    line;
      logic [15:0]    column;
      logic           last;
   } lex_token_type;

   typedef struct packed {
      logic [7:0]    ch;
      logic          eot;
      logic          typed;
      logic          drain;
      lex_token_type want;
   } char_item_type;

   localparam lex_token_type NO_TOKEN = '0;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = '0;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_token_kind;
   logic [1:0]  rsp_operator_code;
   logic [31:0] rsp_number_value;
   logic [7:0]  rsp_digit_count;
   logic [15:0] rsp_line_index;
   logic [15:0] rsp_column_index;
   logic        rsp_last_of_run;

   arithmetic_expression_lexer_core DUT (
      .clock, .reset,
      .req_valid, .req_ready, .req_char_code, .req_end_of_text,
      .rsp_valid, .rsp_ready, .rsp_token_kind, .rsp_operator_code, .rsp_number_value,
      .rsp_digit_count, .rsp_line_index, .rsp_column_index, .rsp_last_of_run
   );

   // Stimulus script and expected tokens
   char_item_type char_script[$];
   char_item_type directed_rows [25];
   lex_token_type expected_tokens[$];
   lex_token_type fresh_tokens[$];
   logic       hold_next = 1'b0;
   int         tokens_waiting = 0;
   int         fault_count = 0;
   int         cycle_count = 0;

   logic [7:0] op_chars [4] = '{CH_PLUS, CH_MINUS, CH_TIMES, CH_DIVIDE};
   logic [7:0] blank_chars [6] = '{CH_SPACE, CH_TAB, CH_VTAB, CH_FORMFEED, CH_CR, CH_NEWLINE};

   // Scanner state mirrored from the block
   logic [15:0] cur_line, cur_col, num_line, num_col;
   logic [31:0] num_value;
   logic [7:0]  num_digits;
   logic        num_active, scan_halted;

   task automatic clear_scanner();
      cur_line = '0;
      cur_col = '0;
      scan_halted = 1'b0;
      num_active = 1'b0;
      num_value = '0;
      num_digits = '0;
      num_line = '0;
      num_col = '0;
   endtask

   task automatic emit_token(input token_kind_type kind, input op_code_type op,
                             input logic [31:0] value, input logic [7:0] digits,
                             input logic [15:0] line, input logic [15:0] column);
      lex_token_type t;
      t.kind = kind;
      t.op = op;
      t.value = value;
      t.digits = digits;
      t.line = line;
      t.column = column;
      t.last = 1'b0;
      fresh_tokens.push_back(t);
   endtask

   task automatic flush_pending();
      if (num_active) begin
         emit_token(TOK_NUMBER, OP_PLUS, num_value, num_digits, num_line, num_col);
         num_active = 1'b0;
         num_value = '0;
         num_digits = '0;
      end
   endtask

   task automatic scan_character(input logic [7:0] ch, input logic eot);
      lex_token_type tail;
      logic [31:0]   d;
      fresh_tokens.delete();
      if (eot) begin
         flush_pending();
         if (!scan_halted)
            emit_token(TOK_END_OF_TEXT, OP_PLUS, '0, 8'd0, cur_line, cur_col);
         clear_scanner();
      end else if (!scan_halted) begin
         if (ch >= CH_ZERO && ch <= CH_NINE) begin
            d = ch - CH_ZERO;
            if (!num_active) begin
               num_active = 1'b1;
               num_value = '0;
               num_digits = '0;
               num_line = cur_line;
               num_col = cur_col;
            end
            if (num_value > (VALUE_MAX - d) / 10)
               num_value = VALUE_MAX;
            else
               num_value = num_value * 10 + d;
            if (num_digits != 8'hFF)
               num_digits++;
         end else begin
            // A number ends before whatever the following character produces.
            flush_pending();
            case (ch)
               CH_SPACE, CH_TAB, CH_NEWLINE, CH_VTAB, CH_FORMFEED, CH_CR: ;
               CH_PLUS:   emit_token(TOK_OPERATOR, OP_PLUS, '0, 8'd1, cur_line, cur_col);
               CH_MINUS:  emit_token(TOK_OPERATOR, OP_MINUS, '0, 8'd1, cur_line, cur_col);
               CH_TIMES:  emit_token(TOK_OPERATOR, OP_TIMES, '0, 8'd1, cur_line, cur_col);
               CH_DIVIDE: emit_token(TOK_OPERATOR, OP_DIVIDE, '0, 8'd1, cur_line, cur_col);
               CH_OPEN:   emit_token(TOK_OPEN, OP_PLUS, '0, 8'd1, cur_line, cur_col);
               CH_CLOSE:  emit_token(TOK_CLOSE, OP_PLUS, '0, 8'd1, cur_line, cur_col);
               default: begin
                  emit_token(TOK_ERROR, OP_PLUS, '0, 8'd1, cur_line, cur_col);
                  scan_halted = 1'b1;
               end
            endcase
         end
         if (!scan_halted) begin
            if (ch == CH_NEWLINE) begin
               if (cur_line != POS_MAX)
                  cur_line++;
               cur_col = '0;
            end else if (cur_col != POS_MAX) begin
               cur_col++;
            end
         end
      end
      if (fresh_tokens.size() > 0) begin
         tail = fresh_tokens.pop_back();
         tail.last = 1'b1;
         fresh_tokens.push_back(tail);
      end
   endtask

   // Script construction
   task automatic push_char(input logic [7:0] ch);
      char_item_type it;
      it = '0;
      it.ch = ch;
      it.drain = hold_next;
      hold_next = 1'b0;
      char_script.push_back(it);
   endtask

   task automatic push_end();
      char_item_type it;
      it = '0;
      it.ch = 8'($urandom_range(0, 255));
      it.eot = 1'b1;
      it.drain = hold_next;
      hold_next = 1'b0;
      char_script.push_back(it);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_char(s[i]);
   endtask

   task automatic push_blank();
      repeat ($urandom_range(0, 2))
         push_char(blank_chars[$urandom_range(0, 5)]);
   endtask

   task automatic push_number();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         push_text("4294967295");
      else if (pick == 1)
         push_text("4294967296");
      else if (pick == 2)
         push_text("0429496729");
      else
         repeat (pick < 17 ? $urandom_range(1, 5) : $urandom_range(6, 14))
            push_char(8'(CH_ZERO + $urandom_range(0, 9)));
   endtask

   task automatic push_expression();
      int unsigned terms, depth;
      terms = $urandom_range(1, 6);
      depth = 0;
      push_blank();
      for (int i = 0; i < terms; i++) begin
         if (i > 0) begin
            push_char(op_chars[$urandom_range(0, 3)]);
            push_blank();
         end
         while (depth < 3 && $urandom_range(0, 3) == 0) begin
            push_char(CH_OPEN);
            depth++;
            push_blank();
         end
         push_number();
         push_blank();
         while (depth > 0 && $urandom_range(0, 2) == 0) begin
            push_char(CH_CLOSE);
            depth--;
            push_blank();
         end
      end
      while (depth > 0) begin
         push_char(CH_CLOSE);
         depth--;
      end
      push_end();
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Sender: bursts of random length separated by random gaps
   char_item_type next_item;
   lex_token_type offer_want;
   logic       offer_typed = 1'b0;
   logic       feed_done = 1'b0;
   int         burst_left, gap_left, since_accept;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = $urandom_range(1, 40);
         gap_left = 0;
         since_accept = 0;
      end else begin
         if (req_valid && req_ready)
            since_accept = 0;
         else if (since_accept < 1000)
            since_accept++;
         if (!req_valid || req_ready) begin
            if (char_script.size() == 0) begin
               req_valid <= 1'b0;
               feed_done <= 1'b1;
            end else if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (char_script[0].drain && (tokens_waiting != 0 || since_accept < 3)) begin
               req_valid <= 1'b0;
            end else begin
               next_item = char_script.pop_front();
               req_valid <= 1'b1;
               req_char_code <= next_item.ch;
               req_end_of_text <= next_item.eot;
               offer_typed <= next_item.typed;
               offer_want <= next_item.want;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = $urandom_range(0, 6);
               end
            end
         end
      end
   end

   // Receiver: its own stall pattern, plus one long hold to fill the token queue
   int         rx_cycle, rx_mode;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_cycle = 0;
         rx_mode = 0;
      end else begin
         rx_cycle++;
         if (rx_cycle % 64 == 0)
            rx_mode = $urandom_range(0, 3);
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
            rsp_ready <= 1'b0;
         else
            case (rx_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= (rx_cycle % 4 == 0);
               default: rsp_ready <= ($urandom_range(0, 3) != 0);
            endcase
      end
   end

   // Prediction on each accepted character, comparison on each accepted token
   lex_token_type seen, want;

   always @(posedge clock) begin
      if (reset) begin
         clear_scanner();
      end else begin
         if (req_valid && req_ready) begin
            scan_character(req_char_code, req_end_of_text);
            if (offer_typed)
               expected_tokens.push_back(offer_want);
            else
               foreach (fresh_tokens[i])
                  expected_tokens.push_back(fresh_tokens[i]);
         end
         if (rsp_valid && rsp_ready) begin
            seen.kind = token_kind_type'(rsp_token_kind);
            seen.op = op_code_type'(rsp_operator_code);
            seen.value = rsp_number_value;
            seen.digits = rsp_digit_count;
            seen.line = rsp_line_index;
            seen.column = rsp_column_index;
            seen.last = rsp_last_of_run;
            if (expected_tokens.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected token: kind %0d value %0d line %0d col %0d",
                           seen.kind, seen.value, seen.line, seen.column);
            end else begin
               want = expected_tokens.pop_front();
               if (seen !== want) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display("token mismatch: expected kind %0d op %0d value %0d digits %0d line %0d col %0d last %0b",
                              want.kind, want.op, want.value, want.digits, want.line,
                              want.column, want.last);
                     $display("                got kind %0d op %0d value %0d digits %0d line %0d col %0d last %0b",
                              seen.kind, seen.op, seen.value, seen.digits, seen.line,
                              seen.column, seen.last);
                  end
               end
            end
         end
         tokens_waiting <= expected_tokens.size();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int first_random;
      int unsigned mode;

      // Directed table: typed expectations only where they are obvious.
      directed_rows = '{
         '{8'hFF,       1'b1, 1'b1, 1'b0, '{TOK_END_OF_TEXT, OP_PLUS, 32'd0, 8'd0, 16'd0, 16'd0, 1'b1}},
         '{CH_OPEN,     1'b0, 1'b1, 1'b0, '{TOK_OPEN, OP_PLUS, 32'd0, 8'd1, 16'd0, 16'd0, 1'b1}},
         '{CH_ZERO,     1'b0, 1'b0, 1'b0, NO_TOKEN},
         '{CH_NINE,     1'b0, 1'b0, 1'b0, NO_TOKEN},
         '{CH_PLUS,     1'b0, 1'b0, 1'b0, NO_TOKEN},
         '{CH_MINUS,    1'b0, 1'b1, 1'b0, '{TOK_OPERATOR, OP_MINUS, 32'd0, 8'd1, 16'd0, 16'd4, 1'b1}},
         '{CH_TIMES,    1'b0, 1'b1, 1'b0, '{TOK_OPERATOR, OP_TIMES, 32'd0, 8'd1, 16'd0, 16'd5, 1'b1}},
         '{CH_DIVIDE,   1'b0, 1'b1, 1'b0, '{TOK_OPERATOR, OP_DIVIDE, 32'd0, 8'd1, 16'd0, 16'd6, 1'b1}},
         '{CH_CLOSE,    1'b0, 1'b1, 1'b0, '{TOK_CLOSE, OP_PLUS, 32'd0, 8'd1, 16'd0, 16'd7, 1'b1}},
         '{CH_NEWLINE,  1'b0, 1'b0, 1'b0, NO_TOKEN},
         '{CH_TAB,      1'b0, 1'b0, 1'b0, NO_TOKEN},
         '{CH_VTAB,     1'b0, 1'b0, 1'b0, NO_TOKEN},
         '{CH_FORMFEED, 1'b0, 1'b0, 1'b0, NO_TOKEN},
         '{CH_CR,       1'b0, 1'b0, 1'b0, NO_TOKEN},
         '{CH_SPACE,    1'b0, 1'b0, 1'b0, NO_TOKEN},
         '{8'h38,       1'b0, 1'b0, 1'b0, NO_TOKEN},
         '{8'hFF,       1'b0, 1'b0, 1'b0, NO_TOKEN},
         '{8'h37,       1'b0, 1'b0, 1'b0, NO_TOKEN},
         '{8'h00,       1'b1, 1'b0, 1'b0, NO_TOKEN},
         '{8'h35,       1'b0, 1'b0, 1'b0, NO_TOKEN},
         '{8'h80,       1'b1, 1'b0, 1'b0, NO_TOKEN},
         '{8'h00,       1'b0, 1'b1, 1'b0, '{TOK_ERROR, OP_PLUS, 32'd0, 8'd1, 16'd0, 16'd0, 1'b1}},
         '{8'h41,       1'b1, 1'b0, 1'b0, NO_TOKEN},
         '{8'h08,       1'b0, 1'b1, 1'b0, '{TOK_ERROR, OP_PLUS, 32'd0, 8'd1, 16'd0, 16'd0, 1'b1}},
         '{8'h7F,       1'b1, 1'b0, 1'b0, NO_TOKEN}
      };
      foreach (directed_rows[i])
         char_script.push_back(directed_rows[i]);

      // Random texts: mostly well-formed expressions, some noise and broken text.
      first_random = char_script.size();
      hold_next = 1'b1;
      while (char_script.size() < first_random + RANDOM_ITEMS) begin
         mode = $urandom_range(0, 9);
         if (mode < 6) begin
            push_expression();
         end else if (mode == 6) begin
            repeat ($urandom_range(1, 12))
               push_char(8'($urandom_range(0, 255)));
            push_end();
         end else if (mode == 7) begin
            push_number();
            push_char(8'($urandom_range(0, 255)));
            push_number();
            push_blank();
            push_end();
         end else if (mode == 8) begin
            repeat ($urandom_range(11, 20))
               push_char(8'(CH_ZERO + $urandom_range(0, 9)));
            push_end();
         end else begin
            push_end();
         end
         if ($urandom_range(0, 24) == 0)
            hold_next = 1'b1;
      end

      // One text with a number long enough to saturate its digit count.
      hold_next = 1'b1;
      push_text("12+(");
      repeat (260)
         push_char(8'(CH_ZERO + $urandom_range(0, 9)));
      push_char(CH_CLOSE);
      push_end();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      wait (feed_done);
      wait (tokens_waiting == 0);
      repeat (10) @(posedge clock);
      if (expected_tokens.size() != 0) begin
         $display("%0d expected tokens never arrived", expected_tokens.size());
         fault_count += expected_tokens.size();
      end
      if (fault_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/aelex_pkg.sv
hw/rtl/aelex_scan.sv
hw/rtl/aelex_queue.sv
hw/rtl/arithmetic_expression_lexer_core.sv
hw/rtl/aelex_checker.sv
test/tb.sv
